/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define AFTSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define AFTSD_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/aftsd_pkg.sv */
package aftsd_pkg;

   // fixed field widths
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned CNT_W   = 17;
   localparam int unsigned SYM_W   = 8;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned DIV_CW  = $clog2(DATA_W);

   // reset value of the halving limit
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

   // count increment on every visit
   localparam logic [CNT_W-1:0] CNT_INC = 17'd2;

   // packed stream widths
   localparam int unsigned REQ_DATA_W = 2 * DATA_W;
   localparam int unsigned RSP_DATA_W = SYM_W + 2 * DATA_W;

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_TOT_RQ  = 14'b00000000000010,
      S_TOTAL   = 14'b00000000000100,
      S_DIV     = 14'b00000000001000,
      S_WALK_RD = 14'b00000000010000,
      S_WALK_EV = 14'b00000000100000,
      S_LEAF    = 14'b00000001000000,
      S_MUL     = 14'b00000010000000,
      S_TOTWR   = 14'b00000100000000,
      S_HV_RD   = 14'b00001000000000,
      S_HV_WR   = 14'b00010000000000,
      S_HV_TOT  = 14'b00100000000000,
      S_RB_RD   = 14'b01000000000000,
      S_RB_WR   = 14'b10000000000000
   } state_type;

endpackage

/* rtl/adaptive_freq_tree_symbol_decoder.sv */
// The result comes from the shared 1-bit-per-cycle divider (two passes) and a tree memory
//   walk with a read state and an evaluate state per level.
// Halving adds a leaf sweep plus a tree rebuild over the memory ports.
// Throughput: one item at a time; the next is accepted once the result is handed over.
// Reset (synchronous, active high) and a start flag run an init pass over all models,
//   during which no item is taken.
module adaptive_freq_tree_symbol_decoder #(
   parameter int unsigned NUM_SYMBOLS = 2,
   parameter int unsigned TREE_LEAVES = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: range_in [31:0], value_in [63:32]
   input  logic [aftsd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: start_req [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: symbol [7:0], range_out [39:8], value_out [71:40]
   output logic [aftsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [aftsd_pkg::LIMIT_W-1:0]     csr_wr_data
);

   localparam int unsigned CW    = $clog2(NUM_SYMBOLS);
   localparam int unsigned LW    = $clog2(TREE_LEAVES);
   localparam int unsigned NW    = LW + 1;
   localparam int unsigned AW    = CW + NW;
   localparam int unsigned TDEPTH = NUM_SYMBOLS * 2 * TREE_LEAVES;
   localparam int unsigned SDEPTH = 2 * TREE_LEAVES;
   localparam int unsigned DW    = aftsd_pkg::DATA_W;
   localparam int unsigned KW    = aftsd_pkg::CNT_W;

   // model memory: node 0 of each context holds its total
   logic [KW-1:0] tree_mem [0:TDEPTH-1];
   // subtree sums for the context being rebuilt
   logic [KW-1:0] sub_mem [0:SDEPTH-1];

   aftsd_pkg::state_type state_ff, state_in;

   logic              init_ff, init_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     ictx_ff, ictx_in;
   logic [CW-1:0]     ctx_ff, ctx_in;
   logic [LW-1:0]     hidx_ff, hidx_in;
   logic [KW-1:0]     sum_ff, sum_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [KW:0]       acc_ff, acc_in;
   logic [KW-1:0]     bound_ff, bound_in;
   logic [KW-1:0]     total_ff, total_in;
   logic [DW-1:0]     step_ff, step_in;
   logic [DW-1:0]     range_ff, range_in;
   logic [DW-1:0]     value_ff, value_in;
   logic [DW-1:0]     div_rem_ff, div_rem_in;
   logic [DW-1:0]     div_quo_ff, div_quo_in;
   logic [DW-1:0]     div_dvs_ff, div_dvs_in;
   logic              div_pass_ff, div_pass_in;
   logic [aftsd_pkg::DIV_CW-1:0] div_cnt_ff, div_cnt_in;
   logic [KW-1:0]     leaf_ff, leaf_in;
   logic [DW-1:0]     accstep_ff, accstep_in;
   logic [aftsd_pkg::SYM_W-1:0] res_sym_ff, res_sym_in;
   logic [DW-1:0]     res_range_ff, res_range_in;
   logic [DW-1:0]     res_value_ff, res_value_in;
   logic [CW-1:0]     res_ctx_ff, res_ctx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [aftsd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [aftsd_pkg::LIMIT_W-1:0]    limit_ff, limit_in;

   logic [KW-1:0]     tree_rd_ff;
   logic [KW-1:0]     sub_a_ff;
   logic [KW-1:0]     sub_b_ff;

   // memory port controls
   logic [AW-1:0]     tr_addr;
   logic              tw_en;
   logic [AW-1:0]     tw_addr;
   logic [KW-1:0]     tw_data;
   logic              sw_en;
   logic [NW-1:0]     sw_addr;
   logic [KW-1:0]     sw_data;
   logic [NW-1:0]     sub_ra;
   logic [NW-1:0]     sub_rb;

   // datapath helpers
   logic [CW-1:0]     mctx;
   logic [DW:0]       div_sh;
   logic              div_ge;
   logic [DW-1:0]     div_quo_nx;
   logic [DW-1:0]     div_rem_nx;
   logic [KW:0]       mul_b;
   logic [DW+KW:0]    mul_full;
   logic [KW:0]       walk_sum;
   logic [KW-1:0]     half_val;
   logic [KW-1:0]     leaf_new;
   logic [KW-1:0]     total_new;
   logic [KW+1:0]     span_end;
   logic [LW-1:0]     leaf_sym;
   logic              accept;
   logic              hand_over;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == aftsd_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign mctx       = init_ff ? ictx_ff : ctx_ff;
   assign hand_over  = !rsp_valid_ff || rsp_tready;

   // restoring divider step, one quotient bit per cycle
   assign div_sh     = {div_rem_ff, div_quo_ff[DW-1]};
   assign div_ge     = (div_sh >= {1'b0, div_dvs_ff});
   assign div_rem_nx = div_ge ? DW'(div_sh - {1'b0, div_dvs_ff}) : div_sh[DW-1:0];
   assign div_quo_nx = {div_quo_ff[DW-2:0], div_ge};

   // shared multiplier: step times acc, then step times leaf
   assign mul_b    = (state_ff == aftsd_pkg::S_LEAF) ? acc_ff : {1'b0, leaf_ff};
   assign mul_full = step_ff * mul_b;

   assign walk_sum  = {1'b0, tree_rd_ff} + acc_ff;
   assign leaf_new  = leaf_ff + aftsd_pkg::CNT_INC;
   assign total_new = total_ff + aftsd_pkg::CNT_INC;
   assign span_end  = {1'b0, acc_ff} + {2'b00, leaf_ff};
   assign leaf_sym  = node_ff[LW-1:0];

   // halve rounding up, or the uniform count during init
   always_comb begin
      if (init_ff) begin
         half_val = ({1'b0, hidx_ff} < (LW+1)'(NUM_SYMBOLS)) ? KW'(1) : '0;
      end else if (tree_rd_ff == '0) begin
         half_val = '0;
      end else begin
         half_val = ((tree_rd_ff - KW'(1)) >> 1) + KW'(1);
      end
   end

   // child addresses of the node being rebuilt
   assign sub_ra = {node_ff[NW-2:0], 1'b0};
   assign sub_rb = {node_ff[NW-2:0], 1'b1};

   // memory port selection
   always_comb begin
      tr_addr = {mctx, node_ff};
      tw_en   = 1'b0;
      tw_addr = {mctx, node_ff};
      tw_data = leaf_new;
      sw_en   = 1'b0;
      sw_addr = node_ff;
      sw_data = sub_a_ff + sub_b_ff;
      case (state_ff)
         aftsd_pkg::S_TOT_RQ: begin
            tr_addr = {mctx, NW'(0)};
         end
         aftsd_pkg::S_HV_RD: begin
            tr_addr = {mctx, 1'b1, hidx_ff};
         end
         aftsd_pkg::S_WALK_EV: begin
            tw_en   = ({1'b0, bound_ff} < walk_sum);
            tw_data = tree_rd_ff + aftsd_pkg::CNT_INC;
         end
         aftsd_pkg::S_MUL: begin
            tw_en   = 1'b1;
         end
         aftsd_pkg::S_TOTWR: begin
            tw_en   = 1'b1;
            tw_addr = {mctx, NW'(0)};
            tw_data = total_new;
         end
         aftsd_pkg::S_HV_WR: begin
            tw_en   = 1'b1;
            tw_addr = {mctx, 1'b1, hidx_ff};
            tw_data = half_val;
            sw_en   = 1'b1;
            sw_addr = {1'b1, hidx_ff};
            sw_data = half_val;
         end
         aftsd_pkg::S_HV_TOT: begin
            tw_en   = 1'b1;
            tw_addr = {mctx, NW'(0)};
            tw_data = sum_ff;
         end
         aftsd_pkg::S_RB_WR: begin
            tw_en   = 1'b1;
            tw_data = sub_a_ff;
            sw_en   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // model memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (tw_en) begin
         tree_mem[tw_addr] <= tw_data;
      end
      tree_rd_ff <= tree_mem[tr_addr];
   end

   // subtree sum memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (sw_en) begin
         sub_mem[sw_addr] <= sw_data;
      end
      sub_a_ff <= sub_mem[sub_ra];
      sub_b_ff <= sub_mem[sub_rb];
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      pend_in      = pend_ff;
      ictx_in      = ictx_ff;
      ctx_in       = ctx_ff;
      hidx_in      = hidx_ff;
      sum_in       = sum_ff;
      node_in      = node_ff;
      acc_in       = acc_ff;
      bound_in     = bound_ff;
      total_in     = total_ff;
      step_in      = step_ff;
      range_in     = range_ff;
      value_in     = value_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dvs_in   = div_dvs_ff;
      div_pass_in  = div_pass_ff;
      div_cnt_in   = div_cnt_ff;
      leaf_in      = leaf_ff;
      accstep_in   = accstep_ff;
      res_sym_in   = res_sym_ff;
      res_range_in = res_range_ff;
      res_value_in = res_value_ff;
      res_ctx_in   = res_ctx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;

      unique case (state_ff)
         aftsd_pkg::S_IDLE: begin
            // take a new transaction; a start flag first runs the init pass
            if (accept) begin
               range_in = req_tdata[DW-1:0];
               value_in = req_tdata[2*DW-1:DW];
               if (req_tuser) begin
                  init_in  = 1'b1;
                  pend_in  = 1'b1;
                  ictx_in  = '0;
                  ctx_in   = '0;
                  hidx_in  = '0;
                  sum_in   = '0;
                  state_in = aftsd_pkg::S_HV_RD;
               end else begin
                  state_in = aftsd_pkg::S_TOT_RQ;
               end
            end
         end
         aftsd_pkg::S_TOT_RQ: begin
            state_in = aftsd_pkg::S_TOTAL;
         end
         aftsd_pkg::S_TOTAL: begin
            // first pass: range over total
            total_in    = tree_rd_ff;
            div_rem_in  = '0;
            div_quo_in  = range_ff;
            div_dvs_in  = DW'(tree_rd_ff);
            div_pass_in = 1'b0;
            div_cnt_in  = '0;
            state_in    = aftsd_pkg::S_DIV;
         end
         aftsd_pkg::S_DIV: begin
            div_rem_in = div_rem_nx;
            div_quo_in = div_quo_nx;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == aftsd_pkg::DIV_CW'(DW - 1)) begin
               if (!div_pass_ff) begin
                  // second pass: value over step
                  step_in     = (total_ff == '0) ? '0 : div_quo_nx;
                  div_rem_in  = '0;
                  div_quo_in  = value_ff;
                  div_dvs_in  = (total_ff == '0) ? '0 : div_quo_nx;
                  div_pass_in = 1'b1;
                  div_cnt_in  = '0;
               end else begin
                  // clamp the quotient below the total
                  if (total_ff == '0) begin
                     bound_in = '0;
                  end else if (div_quo_nx < DW'(total_ff)) begin
                     bound_in = div_quo_nx[KW-1:0];
                  end else begin
                     bound_in = total_ff - KW'(1);
                  end
                  node_in  = NW'(1);
                  acc_in   = '0;
                  state_in = aftsd_pkg::S_WALK_RD;
               end
            end
         end
         aftsd_pkg::S_WALK_RD: begin
            state_in = node_ff[NW-1] ? aftsd_pkg::S_LEAF : aftsd_pkg::S_WALK_EV;
         end
         aftsd_pkg::S_WALK_EV: begin
            // go left and bump the node, or go right and move the base
            if ({1'b0, bound_ff} < walk_sum) begin
               node_in = {node_ff[NW-2:0], 1'b0};
            end else begin
               acc_in  = walk_sum;
               node_in = {node_ff[NW-2:0], 1'b1};
            end
            state_in = aftsd_pkg::S_WALK_RD;
         end
         aftsd_pkg::S_LEAF: begin
            leaf_in    = tree_rd_ff;
            accstep_in = mul_full[DW-1:0];
            state_in   = aftsd_pkg::S_MUL;
         end
         aftsd_pkg::S_MUL: begin
            // last interval takes whatever range is left
            if (span_end < (KW+2)'(total_ff)) begin
               res_range_in = mul_full[DW-1:0];
            end else begin
               res_range_in = range_ff - accstep_ff;
            end
            res_value_in = value_ff - accstep_ff;
            res_sym_in   = aftsd_pkg::SYM_W'(leaf_sym);
            res_ctx_in   = ({1'b0, leaf_sym} < (LW+1)'(NUM_SYMBOLS)) ? CW'(leaf_sym) : '0;
            state_in     = aftsd_pkg::S_TOTWR;
         end
         aftsd_pkg::S_TOTWR: begin
            hidx_in = '0;
            sum_in  = '0;
            if (KW'(limit_ff) <= total_new) begin
               state_in = aftsd_pkg::S_HV_RD;
            end else begin
               state_in = aftsd_pkg::S_IDLE;
               if (hand_over) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {res_value_ff, res_range_ff, res_sym_ff};
                  ctx_in       = res_ctx_ff;
               end else begin
                  state_in = aftsd_pkg::S_TOTWR;
               end
            end
         end
         aftsd_pkg::S_HV_RD: begin
            state_in = aftsd_pkg::S_HV_WR;
         end
         aftsd_pkg::S_HV_WR: begin
            // new leaf into both memories, running total
            sum_in  = sum_ff + half_val;
            hidx_in = hidx_ff + 1'b1;
            if (hidx_ff == LW'(TREE_LEAVES - 1)) begin
               state_in = aftsd_pkg::S_HV_TOT;
            end else begin
               state_in = aftsd_pkg::S_HV_RD;
            end
         end
         aftsd_pkg::S_HV_TOT: begin
            node_in  = NW'(TREE_LEAVES - 1);
            state_in = aftsd_pkg::S_RB_RD;
         end
         aftsd_pkg::S_RB_RD: begin
            state_in = aftsd_pkg::S_RB_WR;
         end
         aftsd_pkg::S_RB_WR: begin
            // left sums from the deepest internal node up to the root
            if (node_ff == NW'(1)) begin
               if (init_ff && (ictx_ff != CW'(NUM_SYMBOLS - 1))) begin
                  ictx_in  = ictx_ff + 1'b1;
                  hidx_in  = '0;
                  sum_in   = '0;
                  state_in = aftsd_pkg::S_HV_RD;
               end else if (init_ff) begin
                  init_in  = 1'b0;
                  pend_in  = 1'b0;
                  state_in = pend_ff ? aftsd_pkg::S_TOT_RQ : aftsd_pkg::S_IDLE;
               end else if (hand_over) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {res_value_ff, res_range_ff, res_sym_ff};
                  ctx_in       = res_ctx_ff;
                  state_in     = aftsd_pkg::S_IDLE;
               end
            end else begin
               node_in  = node_ff - 1'b1;
               state_in = aftsd_pkg::S_RB_RD;
            end
         end
         default: begin
            state_in = aftsd_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aftsd_pkg::S_HV_RD;
         init_ff      <= 1'b1;
         pend_ff      <= 1'b0;
         ictx_ff      <= '0;
         ctx_ff       <= '0;
         hidx_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= aftsd_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         pend_ff      <= pend_in;
         ictx_ff      <= ictx_in;
         ctx_ff       <= ctx_in;
         hidx_ff      <= hidx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      acc_ff       <= acc_in;
      bound_ff     <= bound_in;
      total_ff     <= total_in;
      step_ff      <= step_in;
      range_ff     <= range_in;
      value_ff     <= value_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_dvs_ff   <= div_dvs_in;
      div_pass_ff  <= div_pass_in;
      div_cnt_ff   <= div_cnt_in;
      leaf_ff      <= leaf_in;
      accstep_ff   <= accstep_in;
      res_sym_ff   <= res_sym_in;
      res_range_ff <= res_range_in;
      res_value_ff <= res_value_in;
      res_ctx_ff   <= res_ctx_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

/* rtl/aftsd_checker.sv */
`include "assert_macros.svh"

module aftsd_checker #(
   parameter int unsigned NUM_SYMBOLS = 2
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [aftsd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result stays offered
   `AFTSD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   // a stalled result keeps its payload
   `AFTSD_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "result payload changed while stalled")

   // one transaction at a time: no accept in the cycle after an accept
   `AFTSD_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "input accepted back to back")

   // decoded symbol stays below the number of symbols
   `AFTSD_ASSERT(a_sym_range, clock, reset, rsp_tvalid |-> ({1'b0, rsp_tdata[7:0]} < 9'(NUM_SYMBOLS)), "symbol out of range")

   // reset clears the result and starts the init pass
   `AFTSD_ASSERT_RST(a_reset, clock, reset |=> !rsp_tvalid && !req_tready, "busy state not entered after reset")

endmodule

bind adaptive_freq_tree_symbol_decoder aftsd_checker #(
   .NUM_SYMBOLS (NUM_SYMBOLS)
) u_aftsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* dv/tb_adaptive_freq_tree_symbol_decoder.sv */
`timescale 1ns / 1ps

module tb_adaptive_freq_tree_symbol_decoder;
   import aftsd_pkg::*;

   localparam int unsigned N_SYM       = 2;
   localparam int unsigned N_LEAF      = 2;
   localparam int unsigned N_NODE      = 2 * N_LEAF;
   localparam int          N_PHASES    = 10;
   localparam int          PHASE_ITEMS = 195;
   localparam int          SETTLE      = 120;
   localparam int          WATCHDOG    = 2000;
   localparam int          MAX_REPORTS = 10;

   typedef struct {
      logic             start;
      logic [DATA_W-1:0] rng;
      logic [DATA_W-1:0] val;
   } decode_item_t;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [DATA_W-1:0] range_out;
      logic [DATA_W-1:0] value_out;
   } decode_result_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]      csr_wr_data = LIMIT_RESET;

   // decoder model state
   logic [CNT_W-1:0]   node_count [N_SYM][N_NODE];
   logic [CNT_W-1:0]   model_total [N_SYM];
   logic [SYM_W-1:0]   context_sym;
   logic [LIMIT_W-1:0] limit_setting;

   decode_item_t   pending_items [$];
   decode_result_t expected_symbols [$];

   int items_queued    = 0;
   int results_checked = 0;
   int fail_count      = 0;
   int idle_cycles     = 0;
   int req_wait        = 0;
   int rsp_wait        = 0;
   int req_calm        = 0;
   int rsp_calm        = 0;

   adaptive_freq_tree_symbol_decoder #(
      .NUM_SYMBOLS(N_SYM),
      .TREE_LEAVES(N_LEAF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // left sums from the leaves upwards
   function automatic void rebuild_sums(int ctx);
      logic [CNT_W-1:0] sub [N_NODE];
      for (int n = N_LEAF; n < N_NODE; n++) sub[n] = node_count[ctx][n];
      for (int n = N_LEAF - 1; n >= 1; n--) begin
         sub[n] = sub[2*n] + sub[2*n+1];
         node_count[ctx][n] = sub[2*n];
      end
   endfunction

   // uniform counts in every context
   function automatic void reset_models();
      for (int c = 0; c < N_SYM; c++) begin
         for (int n = 0; n < N_NODE; n++) node_count[c][n] = '0;
         for (int i = 0; i < N_SYM; i++) node_count[c][N_LEAF+i] = 1;
         model_total[c] = CNT_W'(N_SYM);
         rebuild_sums(c);
      end
      context_sym = '0;
   endfunction

   // halve every symbol leaf, rounding up
   function automatic void halve_counts(int ctx);
      logic [CNT_W-1:0] f;
      logic [CNT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < N_SYM; i++) begin
         f = node_count[ctx][N_LEAF+i];
         f = (f == 0) ? '0 : ((f - 1) >> 1) + 1;
         node_count[ctx][N_LEAF+i] = f;
         sum = sum + f;
      end
      model_total[ctx] = sum;
      rebuild_sums(ctx);
   endfunction

   // decode one symbol and queue what the block should return
   function automatic void predict_symbol(logic start, logic [DATA_W-1:0] rng,
                                          logic [DATA_W-1:0] val);
      int ctx;
      int node;
      logic [DATA_W-1:0] total, step, quot, bound, acc, span, leaf, acc_step;
      decode_result_t res;
      if (start) reset_models();
      ctx = (context_sym < N_SYM) ? int'(context_sym) : 0;
      total = DATA_W'(model_total[ctx]);
      step = (total != 0) ? rng / total : '0;
      quot = (step != 0) ? val / step : '1;
      bound = (total == 0) ? '0 : ((quot < total) ? quot : total - 1);
      // walk from the root, counting every left turn
      node = 1;
      acc = '0;
      while (node < N_LEAF) begin
         span = DATA_W'(node_count[ctx][node]) + acc;
         if (bound < span) begin
            node_count[ctx][node] = node_count[ctx][node] + CNT_INC;
            node = 2 * node;
         end else begin
            acc = span;
            node = 2 * node + 1;
         end
      end
      leaf = DATA_W'(node_count[ctx][node]);
      acc_step = step * acc;
      res.range_out = (acc + leaf < total) ? step * leaf : rng - acc_step;
      res.value_out = val - acc_step;
      res.symbol = SYM_W'(node - N_LEAF);
      // adapt the model
      node_count[ctx][node] = node_count[ctx][node] + CNT_INC;
      model_total[ctx] = model_total[ctx] + CNT_INC;
      if (DATA_W'(limit_setting) <= DATA_W'(model_total[ctx])) halve_counts(ctx);
      context_sym = res.symbol;
      expected_symbols.push_back(res);
   endfunction

   // idle length per transaction, with occasional runs of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   task automatic queue_item(logic start, logic [DATA_W-1:0] rng, logic [DATA_W-1:0] val);
      decode_item_t it;
      it.start = start;
      it.rng = rng;
      it.val = val;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // mostly normalized range with value below it, the rest odd corners
   task automatic queue_random_item();
      logic [DATA_W-1:0] rng, val;
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         rng = $urandom_range(32'hFFFF_FFFF, 32'h0100_0000);
         val = $urandom_range(rng - 1, 0);
      end else if (kind < 85) begin
         rng = $urandom;
         val = $urandom;
      end else if (kind < 93) begin
         rng = $urandom_range(15, 0);
         val = ($urandom_range(0, 1) != 0) ? $urandom_range(15, 0) : $urandom;
      end else begin
         rng = $urandom_range(32'hFFFF_FFFF, 32'h0100_0000);
         val = $urandom_range(32'hFFFF_FFFF, rng);
      end
      queue_item($urandom_range(0, 63) == 0, rng, val);
   endtask

   task automatic wait_drained();
      while (results_checked < items_queued) @(posedge clock);
   endtask

   task automatic program_limit(logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      limit_setting = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic note_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch in %s at result %0d: expected %h, got %h",
                  field, results_checked, want, got);
   endtask

   // request driver
   always @(posedge clock) begin : req_drive
      decode_item_t it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_symbol(req_tuser, req_tdata[DATA_W-1:0], req_tdata[2*DATA_W-1:DATA_W]);
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               if (req_tready) req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_tdata <= {it.val, it.rng};
               req_tuser <= it.start;
               req_tvalid <= 1'b1;
               req_wait = draw_wait(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : rsp_check
      decode_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_symbols.size() == 0) begin
               note_mismatch("symbol of unexpected transaction", '0,
                             DATA_W'(rsp_tdata[SYM_W-1:0]));
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tdata[SYM_W-1:0] !== want.symbol)
                  note_mismatch("symbol", DATA_W'(want.symbol), DATA_W'(rsp_tdata[SYM_W-1:0]));
               if (rsp_tdata[SYM_W+DATA_W-1:SYM_W] !== want.range_out)
                  note_mismatch("range_out", want.range_out, rsp_tdata[SYM_W+DATA_W-1:SYM_W]);
               if (rsp_tdata[SYM_W+2*DATA_W-1:SYM_W+DATA_W] !== want.value_out)
                  note_mismatch("value_out", want.value_out,
                                rsp_tdata[SYM_W+2*DATA_W-1:SYM_W+DATA_W]);
            end
            rsp_wait = draw_wait(rsp_calm);
         end
         // stall counts only while a result is on offer
         if (rsp_wait > 0) begin
            if (rsp_tvalid) rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      logic [LIMIT_W-1:0] limits [N_PHASES];
      reset_models();
      limit_setting = LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners under the reset limit
      queue_item(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(1'b0, 32'h0000_0000, 32'h0000_0000);
      queue_item(1'b0, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_item(1'b0, 32'h0100_0000, 32'h0000_0000);
      queue_item(1'b0, 32'h0100_0000, 32'h00FF_FFFF);
      queue_item(1'b0, 32'h0000_0005, 32'h0000_0002);
      queue_item(1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_item(1'b0, 32'h1234_5678, 32'h0000_0000);
      queue_item(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFD);
      queue_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_item(1'b1, 32'h0000_0002, 32'h0000_0001);
      queue_item(1'b1, 32'h0000_0003, 32'h0000_0003);
      queue_item(1'b0, 32'h0000_0004, 32'h0000_0001);
      queue_item(1'b0, 32'hF000_0000, 32'hEFFF_FFFF);
      queue_item(1'b0, 32'h0F00_0000, 32'h0000_0001);
      wait_drained();

      // limit settings per phase, extremes and tiny values among them
      limits = '{16'd4, 16'd0, 16'd65535, 16'd1, 16'd3, 16'd5,
                 LIMIT_RESET, 16'd2, 16'd6, 16'd4};
      limits[5] = $urandom_range(5, 40);
      limits[8] = $urandom_range(41, 400);
      for (int p = 0; p < N_PHASES; p++) begin
         program_limit(limits[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
         wait_drained();
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/aftsd_pkg.sv
rtl/adaptive_freq_tree_symbol_decoder.sv
rtl/aftsd_checker.sv
dv/tb_adaptive_freq_tree_symbol_decoder.sv
